// ===== rtl/sbf_pkg.sv =====
// Shared types and codes for the store buffer with load forwarding.
`default_nettype none
package sbf_pkg;
	localparam int ADDR_W = 48;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int NBYTES = 8;

	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_DONE  = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [2:0] KIND_QUEUED    = 3'd0;
	localparam logic [2:0] KIND_ISSUE     = 3'd1;
	localparam logic [2:0] KIND_FORWARD   = 3'd2;
	localparam logic [2:0] KIND_RETRY     = 3'd3;
	localparam logic [2:0] KIND_LOAD_DONE = 3'd4;
	localparam logic [2:0] KIND_DRAINED   = 3'd5;
	localparam logic [2:0] KIND_FLUSH_ACK = 3'd6;
	localparam logic [2:0] KIND_REJECT    = 3'd7;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
	} query_t;

	typedef struct packed {
		logic              line_hit;
		logic [NBYTES-1:0] byte_hit;
		logic [DATA_W-1:0] bytes;
	} match_t;
endpackage
`default_nettype wire

// ===== rtl/sbf_cell.sv =====
// One store buffer cell: holds a store and matches it against the current load.
`default_nettype none
module sbf_cell #(
	parameter int LINE_BYTES = 64
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire sbf_pkg::entry_t wr_entry,
	input  wire logic            shift_en,
	input  wire sbf_pkg::entry_t nbr_entry,
	input  wire sbf_pkg::query_t query,
	output sbf_pkg::entry_t      entry,
	output sbf_pkg::match_t      hit
);
	localparam int OFFW = $clog2(LINE_BYTES);

	sbf_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q <= wr_entry;
		end else if (shift_en) begin
			entry_q <= nbr_entry;
		end
	end

	assign entry = entry_q;

	always_comb begin
		logic [OFFW:0] o;
		logic [OFFW:0] e_lo;
		logic [OFFW:0] e_hi;
		logic [OFFW:0] b;
		logic          line;
		logic          inr;
		line = entry_q.addr[sbf_pkg::ADDR_W-1:OFFW] == query.addr[sbf_pkg::ADDR_W-1:OFFW];
		e_lo = (OFFW+1)'(entry_q.addr[OFFW-1:0]);
		e_hi = e_lo + (OFFW+1)'(entry_q.len);
		hit.line_hit = line;
		for (int j = 0; j < sbf_pkg::NBYTES; j++) begin
			o = (OFFW+1)'(query.addr[OFFW-1:0]) + (OFFW+1)'(j);
			inr = (sbf_pkg::LEN_W'(j) < query.len) && (o >= e_lo) && (o < e_hi);
			b = o - e_lo;
			hit.byte_hit[j] = inr && line;
			hit.bytes[j*8 +: 8] = entry_q.data[b[2:0]*8 +: 8];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/store_buffer_with_load_forwarding_core.sv =====
// Top level of the store buffer with store-to-load forwarding.
// Stores sit in a row of cells, oldest in cell 0; a completion shifts every cell down one.
// Store, completion and flush commands produce their registered result in the cycle after the transfer.
// A load scans the held stores one cell per cycle through the cell read mux (none in bypass
// mode) before its result is registered; no new command is taken during the scan or while a
// finished result is stalled at the output.
`default_nettype none
module store_buffer_with_load_forwarding_core #(
	parameter int DEPTH        = 16,
	parameter int LINE_BYTES   = 64,
	parameter int ACCESS_BYTES = 8,
	parameter int TAG_BITS     = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [47:0] addr,
	input  wire logic [3:0]  len,
	input  wire logic [63:0] data,
	input  wire logic [7:0]  tag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [47:0]      mem_addr,
	output logic [3:0]       mem_len,
	output logic [63:0]      mem_data,
	output logic             mem_is_store,
	output logic [7:0]       req_tag,
	output logic [63:0]      load_data,
	output logic             buffer_full,
	output logic             flushing,
	output logic [4:0]       count
);
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int OFFW = $clog2(LINE_BYTES);
	localparam int TW   = (TAG_BITS > 8) ? TAG_BITS : 8;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	sbf_pkg::entry_t ent [DEPTH];
	sbf_pkg::entry_t nbr [DEPTH];
	sbf_pkg::match_t hit [DEPTH];
	sbf_pkg::entry_t new_entry;
	sbf_pkg::query_t query_q;
	sbf_pkg::match_t sel;

	logic                st_q, n_st;
	logic [CW-1:0]       cnt_q, n_cnt, scan_idx_q, n_idx;
	logic                full_q, n_full, flush_q, n_flush, stalled_q, n_stalled;
	logic [TAG_BITS-1:0] store_tag_q, n_stag, next_tag_q, n_ntag;
	logic [4:0]          cap_q;
	logic                found_q, n_found;
	logic [7:0]          cov_q, n_cov;
	logic [63:0]         val_q, n_val;
	logic                q_load, push, shift;

	logic        ov_q, mis_q;
	logic [2:0]  kind_q;
	logic [47:0] maddr_q;
	logic [3:0]  mlen_q;
	logic [63:0] mdata_q, ld_q;
	logic [7:0]  rtag_q;
	logic        r_valid, r_mis;
	logic [2:0]  r_kind;
	logic [47:0] r_maddr;
	logic [3:0]  r_mlen;
	logic [63:0] r_mdata, r_ld;
	logic [7:0]  r_rtag;

	logic [6:0]    cap7, effcap, cnt7, ncap7, neffcap;
	logic          bypass, accept, out_busy;
	logic [3:0]    l_clamp, elen;
	logic [OFFW:0] room;
	logic [63:0]   mdata;
	logic [7:0]    lmask;
	logic [TW-1:0] tag_x, nt_x;

	assign cap7   = 7'(cap_q);
	assign effcap = (cap7 > 7'(DEPTH)) ? 7'(DEPTH) : cap7;
	assign cnt7   = 7'(cnt_q);
	assign bypass = cap_q == 5'd0;
	assign ncap7  = 7'(cfg_wdata);
	assign neffcap = (ncap7 > 7'(DEPTH)) ? 7'(DEPTH) : ncap7;

	assign out_busy = ov_q && out_stall;
	assign in_stall = (st_q != ST_IDLE) || out_busy;
	assign accept   = in_valid && !in_stall;

	// effective access length and masked store data
	always_comb begin
		l_clamp = (len > 4'(ACCESS_BYTES)) ? 4'(ACCESS_BYTES) : len;
		room = (OFFW+1)'(LINE_BYTES) - (OFFW+1)'(addr[OFFW-1:0]);
		elen = ((OFFW+1)'(l_clamp) > room) ? 4'(room) : l_clamp;
		for (int j = 0; j < 8; j++) begin
			mdata[j*8 +: 8] = (4'(j) < elen) ? data[j*8 +: 8] : 8'd0;
			lmask[j] = 4'(j) < query_q.len;
		end
	end

	assign new_entry = '{addr: addr, len: elen, data: mdata};
	assign tag_x = TW'(tag);
	assign nt_x  = TW'(next_tag_q);
	assign sel   = hit[scan_idx_q[PW-1:0]];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			if (gi + 1 < DEPTH) begin : g_nb
				assign nbr[gi] = ent[gi+1];
			end else begin : g_last
				assign nbr[gi] = ent[gi];
			end
			sbf_cell #(.LINE_BYTES(LINE_BYTES)) u_cell (
				.clk       (clk),
				.wr_en     (push && (cnt_q == CW'(gi))),
				.wr_entry  (new_entry),
				.shift_en  (shift),
				.nbr_entry (nbr[gi]),
				.query     (query_q),
				.entry     (ent[gi]),
				.hit       (hit[gi])
			);
		end
	endgenerate

	always_comb begin
		n_st = st_q; n_cnt = cnt_q; n_idx = scan_idx_q;
		n_full = full_q; n_flush = flush_q; n_stalled = stalled_q;
		n_stag = store_tag_q; n_ntag = next_tag_q;
		n_found = found_q; n_cov = cov_q; n_val = val_q;
		q_load = 1'b0; push = 1'b0; shift = 1'b0;
		r_valid = 1'b0; r_kind = sbf_pkg::KIND_QUEUED; r_maddr = '0; r_mlen = '0;
		r_mdata = '0; r_mis = 1'b0; r_rtag = '0; r_ld = '0;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					r_valid = 1'b1;
					case (cmd)
						sbf_pkg::CMD_STORE: begin
							if (bypass) begin
								r_kind = sbf_pkg::KIND_ISSUE; r_maddr = addr; r_mlen = elen;
								r_mdata = mdata; r_mis = 1'b1; r_rtag = nt_x[7:0];
								n_ntag = next_tag_q + 1'b1;
							end else if (cnt7 >= effcap) begin
								r_kind = sbf_pkg::KIND_REJECT;
							end else begin
								push = 1'b1;
								n_cnt = cnt_q + 1'b1;
								if (cnt7 + 7'd1 >= effcap) n_full = 1'b1;
								if (stalled_q) begin
									// buffer was empty: the new store is the head
									r_kind = sbf_pkg::KIND_ISSUE; r_maddr = addr; r_mlen = elen;
									r_mdata = mdata; r_mis = 1'b1; r_rtag = nt_x[7:0];
									n_stag = next_tag_q; n_ntag = next_tag_q + 1'b1;
									n_stalled = 1'b0;
								end
							end
						end
						sbf_pkg::CMD_LOAD: begin
							r_valid = 1'b0;
							q_load = 1'b1;
							n_st = ST_SCAN; n_idx = '0;
							n_found = 1'b0; n_cov = '0; n_val = '0;
						end
						sbf_pkg::CMD_DONE: begin
							if (!stalled_q && cnt_q != '0 && tag_x[TAG_BITS-1:0] == store_tag_q) begin
								shift = 1'b1;
								n_cnt = cnt_q - 1'b1;
								n_full = 1'b0;
								if (cnt_q != CW'(1)) begin
									r_kind = sbf_pkg::KIND_ISSUE; r_maddr = nbr[0].addr;
									r_mlen = nbr[0].len; r_mdata = nbr[0].data; r_mis = 1'b1;
									r_rtag = nt_x[7:0];
									n_stag = next_tag_q; n_ntag = next_tag_q + 1'b1;
								end else begin
									r_kind = sbf_pkg::KIND_DRAINED;
									n_flush = 1'b0; n_stalled = 1'b1;
								end
							end else begin
								r_kind = sbf_pkg::KIND_LOAD_DONE; r_rtag = tag;
							end
						end
						default: begin
							if (!bypass) n_flush = cnt_q != '0;
							r_kind = sbf_pkg::KIND_FLUSH_ACK;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (bypass || scan_idx_q == cnt_q) begin
					if (!out_busy) begin
						r_valid = 1'b1;
						n_st = ST_IDLE;
						if (!found_q) begin
							r_kind = sbf_pkg::KIND_ISSUE; r_maddr = query_q.addr;
							r_mlen = query_q.len; r_rtag = nt_x[7:0];
							n_ntag = next_tag_q + 1'b1;
						end else if (cov_q == lmask) begin
							r_kind = sbf_pkg::KIND_FORWARD; r_ld = val_q;
						end else begin
							r_kind = sbf_pkg::KIND_RETRY;
						end
					end
				end else begin
					// fold one cell per cycle, oldest first so younger bytes win
					n_idx = scan_idx_q + 1'b1;
					n_found = found_q | sel.line_hit;
					n_cov = cov_q | sel.byte_hit;
					for (int j = 0; j < 8; j++) begin
						if (sel.byte_hit[j]) n_val[j*8 +: 8] = sel.bytes[j*8 +: 8];
					end
				end
			end
			default: n_st = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; cnt_q <= '0; scan_idx_q <= '0;
			full_q <= 1'b0; flush_q <= 1'b0; stalled_q <= 1'b1;
			store_tag_q <= '0; next_tag_q <= '0; cap_q <= 5'd8;
			ov_q <= 1'b0;
		end else begin
			st_q <= n_st; cnt_q <= n_cnt; scan_idx_q <= n_idx;
			flush_q <= n_flush; stalled_q <= n_stalled;
			store_tag_q <= n_stag; next_tag_q <= n_ntag;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
				full_q <= (neffcap != 7'd0) && (cnt7 >= neffcap);
			end else begin
				full_q <= n_full;
			end
			if (r_valid) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_load) query_q <= '{addr: addr, len: elen};
		found_q <= n_found; cov_q <= n_cov; val_q <= n_val;
		if (r_valid) begin
			kind_q <= r_kind; maddr_q <= r_maddr; mlen_q <= r_mlen; mdata_q <= r_mdata;
			mis_q <= r_mis; rtag_q <= r_rtag; ld_q <= r_ld;
		end
	end

	// status fields reflect state after the transfer that produced the result
	logic [4:0] cnt_out_q;
	logic       full_out_q, flush_out_q;
	always_ff @(posedge clk) begin
		if (r_valid) begin
			cnt_out_q <= 5'(n_cnt); full_out_q <= n_full; flush_out_q <= n_flush;
		end
	end

	assign out_valid    = ov_q;
	assign kind         = kind_q;
	assign mem_addr     = maddr_q;
	assign mem_len      = mlen_q;
	assign mem_data     = mdata_q;
	assign mem_is_store = mis_q;
	assign req_tag      = rtag_q;
	assign load_data    = ld_q;
	assign buffer_full  = full_out_q;
	assign flushing     = flush_out_q;
	assign count        = cnt_out_q;
endmodule
`default_nettype wire

// ===== rtl/sbf_checker.sv =====
// Port-level checks for the store buffer core, bound to the top level.
`default_nettype none
module sbf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  kind,
	input wire logic        mem_is_store,
	input wire logic        flushing,
	input wire logic [4:0]  count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind))
		else $error("result dropped or changed while stalled");

	// a reject needs a nonzero capacity that the held count has reached
	a_reject_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sbf_pkg::KIND_REJECT |-> count != 5'd0 && !mem_is_store)
		else $error("store rejected while buffer empty");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == sbf_pkg::KIND_DRAINED |-> count == 5'd0 && !flushing)
		else $error("drain reported with stores held or flush pending");

	a_fwd_no_mem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == sbf_pkg::KIND_FORWARD || kind == sbf_pkg::KIND_RETRY)
		|-> !mem_is_store)
		else $error("forward or retry flagged as memory store");
endmodule

bind store_buffer_with_load_forwarding_core sbf_checker u_sbf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.mem_is_store (mem_is_store),
	.flushing     (flushing),
	.count        (count)
);
`default_nettype wire
